@@ src/mwm_pkg.sv @@
// Shared types and constants of the mecanum wheel mixer.
// Used by every module in src; depends on nothing.
package mwm_pkg;

   // Command and wheel words are 16-bit signed fixed point.
   localparam int CMD_W         = 16;
   // Sum of three commands: two extra bits keep it exact.
   localparam int SUM_W         = CMD_W + 2;
   // Magnitude of such a sum fits one bit less than the sum.
   localparam int MAG_W         = SUM_W - 1;
   localparam int NUM_WHEELS    = 4;
   localparam int FRAC_BITS_DEF = 14;

   // Wheel lane order.
   localparam int WHL_FL = 0;
   localparam int WHL_FR = 1;
   localparam int WHL_RL = 2;
   localparam int WHL_RR = 3;

   // Saturation limits of a 16-bit signed wheel word.
   localparam logic [MAG_W-1:0] SAT_POS_MAG = MAG_W'(32767);
   localparam logic [MAG_W-1:0] SAT_NEG_MAG = MAG_W'(32768);

   typedef logic signed [CMD_W-1:0]                cmd_type;
   typedef logic [NUM_WHEELS-1:0][MAG_W-1:0]       mag_vec_type;
   typedef logic [NUM_WHEELS-1:0]                  sign_vec_type;

   typedef struct packed {
      logic stop;
      logic scaled;
   } flags_type;

endpackage

@@ src/mwm_mix.sv @@
// Input skid stage, wheel sums, magnitudes and largest magnitude.
// Depends on mwm_pkg.
module mwm_mix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mwm_pkg::cmd_type      req_forward_cmd,
   input  mwm_pkg::cmd_type      req_strafe_cmd,
   input  mwm_pkg::cmd_type      req_rotate_cmd,
   output logic                  out_valid,
   output mwm_pkg::sign_vec_type out_sign,
   output mwm_pkg::mag_vec_type  out_mag,
   output logic [mwm_pkg::MAG_W-1:0] out_max,
   output mwm_pkg::flags_type    out_flags
);

   localparam int SW = mwm_pkg::SUM_W;
   localparam int MW = mwm_pkg::MAG_W;

   logic             skid_valid_ff, skid_valid_in;
   mwm_pkg::cmd_type skid_f_ff, skid_s_ff, skid_r_ff;

   logic             src_valid;
   mwm_pkg::cmd_type src_f, src_s, src_r;
   logic signed [SW-1:0] f_x, s_x, r_x;

   logic                 s1_valid_ff, s1_stop_ff;
   logic signed [SW-1:0] s1_sum_ff [mwm_pkg::NUM_WHEELS];
   logic signed [SW-1:0] sum_in    [mwm_pkg::NUM_WHEELS];

   logic                  s2_valid_ff, s2_stop_ff;
   mwm_pkg::sign_vec_type s2_sign_ff, sign_in;
   mwm_pkg::mag_vec_type  s2_mag_ff, mag_in;

   logic                  s3_valid_ff, s3_stop_ff;
   mwm_pkg::sign_vec_type s3_sign_ff;
   mwm_pkg::mag_vec_type  s3_mag_ff;
   logic [MW-1:0]         s3_max_ff, max_in, max_a, max_b;

   // The skid word holds one command taken while the pipeline is stalled.
   assign req_stall = skid_valid_ff;
   assign src_valid = skid_valid_ff || req_valid;
   assign src_f     = skid_valid_ff ? skid_f_ff : req_forward_cmd;
   assign src_s     = skid_valid_ff ? skid_s_ff : req_strafe_cmd;
   assign src_r     = skid_valid_ff ? skid_r_ff : req_rotate_cmd;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (en) begin
         skid_valid_in = 1'b0;
      end else if (req_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
      end
   end

   assign f_x = SW'(src_f);
   assign s_x = SW'(src_s);
   assign r_x = SW'(src_r);

   assign sum_in[mwm_pkg::WHL_FL] = f_x + s_x + r_x;
   assign sum_in[mwm_pkg::WHL_FR] = f_x - s_x - r_x;
   assign sum_in[mwm_pkg::WHL_RL] = f_x - s_x + r_x;
   assign sum_in[mwm_pkg::WHL_RR] = f_x + s_x - r_x;

   always_comb begin
      for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
         sign_in[i] = s1_sum_ff[i][SW-1];
         mag_in[i]  = s1_sum_ff[i][SW-1] ? MW'(-s1_sum_ff[i]) : MW'(s1_sum_ff[i]);
      end
   end

   assign max_a  = (s2_mag_ff[0] > s2_mag_ff[1]) ? s2_mag_ff[0] : s2_mag_ff[1];
   assign max_b  = (s2_mag_ff[2] > s2_mag_ff[3]) ? s2_mag_ff[2] : s2_mag_ff[3];
   assign max_in = (max_a > max_b) ? max_a : max_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (en) begin
            s1_valid_ff <= src_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_f_ff <= req_forward_cmd;
         skid_s_ff <= req_strafe_cmd;
         skid_r_ff <= req_rotate_cmd;
      end
      if (en) begin
         s1_sum_ff  <= sum_in;
         s1_stop_ff <= (src_f == '0) && (src_s == '0) && (src_r == '0);
         s2_sign_ff <= sign_in;
         s2_mag_ff  <= mag_in;
         s2_stop_ff <= s1_stop_ff;
         s3_sign_ff <= s2_sign_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_max_ff  <= max_in;
         s3_stop_ff <= s2_stop_ff;
      end
   end

   assign out_valid        = s3_valid_ff;
   assign out_sign         = s3_sign_ff;
   assign out_mag          = s3_mag_ff;
   assign out_max          = s3_max_ff;
   assign out_flags.stop   = s3_stop_ff;
   assign out_flags.scaled = 1'b0;

endmodule

@@ src/mwm_div.sv @@
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Forms |wheel| * 2^FRAC_BITS / max; depends on mwm_pkg.
module mwm_div #(
   parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  mwm_pkg::sign_vec_type     in_sign,
   input  mwm_pkg::mag_vec_type      in_mag,
   input  logic [mwm_pkg::MAG_W-1:0] in_max,
   input  mwm_pkg::flags_type        in_flags,
   output logic                      out_valid,
   output mwm_pkg::sign_vec_type     out_sign,
   output mwm_pkg::mag_vec_type      out_mag,
   output logic [mwm_pkg::NUM_WHEELS-1:0][FRAC_BITS:0] out_quo,
   output mwm_pkg::flags_type        out_flags
);

   localparam int MW = mwm_pkg::MAG_W;
   localparam int NW = mwm_pkg::NUM_WHEELS;
   localparam int NS = FRAC_BITS + 1;
   localparam int QW = FRAC_BITS + 1;
   localparam int CW = (QW > MW) ? QW : MW;

   logic                  st_valid_ff [NS];
   mwm_pkg::sign_vec_type st_sign_ff  [NS];
   mwm_pkg::mag_vec_type  st_mag_ff   [NS];
   mwm_pkg::mag_vec_type  st_rem_ff   [NS];
   logic [MW-1:0]         st_max_ff   [NS];
   logic [NW-1:0][QW-1:0] st_quo_ff   [NS];
   mwm_pkg::flags_type    st_flags_ff [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         logic                  valid_prev;
         mwm_pkg::sign_vec_type sign_prev;
         mwm_pkg::mag_vec_type  mag_prev;
         logic [MW-1:0]         max_prev;
         mwm_pkg::flags_type    flags_prev, flags_in;
         mwm_pkg::mag_vec_type  rem_in;
         logic [NW-1:0][QW-1:0] quo_prev;
         logic [NW-1:0][QW-1:0] quo_in;
         logic [NW-1:0][MW:0]   trial;

         if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign sign_prev  = in_sign;
            assign mag_prev   = in_mag;
            assign max_prev   = in_max;
            assign flags_prev = in_flags;
            assign quo_prev   = '0;
            always_comb begin
               for (int l = 0; l < NW; l++) begin
                  trial[l] = {1'b0, in_mag[l]};
               end
            end
            // Scaling applies only when the largest wheel exceeds 1.0.
            assign flags_in.stop   = flags_prev.stop;
            assign flags_in.scaled = CW'(in_max) > (CW'(1) << FRAC_BITS);
         end else begin : g_next
            assign valid_prev = st_valid_ff[k-1];
            assign sign_prev  = st_sign_ff[k-1];
            assign mag_prev   = st_mag_ff[k-1];
            assign max_prev   = st_max_ff[k-1];
            assign flags_prev = st_flags_ff[k-1];
            assign quo_prev   = st_quo_ff[k-1];
            always_comb begin
               for (int l = 0; l < NW; l++) begin
                  trial[l] = {st_rem_ff[k-1][l], 1'b0};
               end
            end
            assign flags_in = flags_prev;
         end

         always_comb begin
            for (int l = 0; l < NW; l++) begin
               if (trial[l] >= {1'b0, max_prev}) begin
                  rem_in[l] = MW'(trial[l] - {1'b0, max_prev});
                  quo_in[l] = {quo_prev[l][QW-2:0], 1'b1};
               end else begin
                  rem_in[l] = MW'(trial[l]);
                  quo_in[l] = {quo_prev[l][QW-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               st_valid_ff[k] <= 1'b0;
            end else if (en) begin
               st_valid_ff[k] <= valid_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               st_sign_ff[k]  <= sign_prev;
               st_mag_ff[k]   <= mag_prev;
               st_rem_ff[k]   <= rem_in;
               st_max_ff[k]   <= max_prev;
               st_quo_ff[k]   <= quo_in;
               st_flags_ff[k] <= flags_in;
            end
         end
      end
   endgenerate

   assign out_valid = st_valid_ff[NS-1];
   assign out_sign  = st_sign_ff[NS-1];
   assign out_mag   = st_mag_ff[NS-1];
   assign out_quo   = st_quo_ff[NS-1];
   assign out_flags = st_flags_ff[NS-1];

endmodule

@@ src/mwm_out.sv @@
// Output stage: picks scaled or plain magnitude, applies sign, saturates,
// and holds the result word. Depends on mwm_pkg.
module mwm_out #(
   parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  mwm_pkg::sign_vec_type in_sign,
   input  mwm_pkg::mag_vec_type  in_mag,
   input  logic [mwm_pkg::NUM_WHEELS-1:0][FRAC_BITS:0] in_quo,
   input  mwm_pkg::flags_type    in_flags,
   output logic                  rsp_valid,
   output mwm_pkg::cmd_type      rsp_front_left,
   output mwm_pkg::cmd_type      rsp_front_right,
   output mwm_pkg::cmd_type      rsp_rear_left,
   output mwm_pkg::cmd_type      rsp_rear_right,
   output logic                  rsp_stop_all,
   output logic                  rsp_was_scaled
);

   localparam int MW = mwm_pkg::MAG_W;
   localparam int NW = mwm_pkg::NUM_WHEELS;
   localparam int QW = FRAC_BITS + 1;
   localparam int RW = (QW > MW) ? QW : MW;
   localparam int CW = mwm_pkg::CMD_W;

   logic [RW-1:0]        res   [NW];
   logic [RW-1:0]        neg   [NW];
   mwm_pkg::cmd_type     wheel [NW];

   logic                 rsp_valid_ff;
   mwm_pkg::cmd_type     wheel_ff [NW];
   logic                 stop_ff, scaled_ff;

   always_comb begin
      for (int l = 0; l < NW; l++) begin
         res[l] = in_flags.scaled ? RW'(in_quo[l]) : RW'(in_mag[l]);
         neg[l] = -res[l];
         if (in_sign[l]) begin
            if (res[l] > RW'(mwm_pkg::SAT_NEG_MAG)) begin
               wheel[l] = CW'(-32768);
            end else begin
               wheel[l] = CW'(neg[l]);
            end
         end else begin
            if (res[l] > RW'(mwm_pkg::SAT_POS_MAG)) begin
               wheel[l] = CW'(32767);
            end else begin
               wheel[l] = CW'(res[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wheel_ff  <= wheel;
         stop_ff   <= in_flags.stop;
         scaled_ff <= in_flags.scaled;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_left  = wheel_ff[mwm_pkg::WHL_FL];
   assign rsp_front_right = wheel_ff[mwm_pkg::WHL_FR];
   assign rsp_rear_left   = wheel_ff[mwm_pkg::WHL_RL];
   assign rsp_rear_right  = wheel_ff[mwm_pkg::WHL_RR];
   assign rsp_stop_all    = stop_ff;
   assign rsp_was_scaled  = scaled_ff;

endmodule

@@ src/mecanum_wheel_mixer_top.sv @@
// Mecanum wheel mixer. A command word passes the mixer, divider and output
// registers on its way to a result word. Throughput: one command word per
// cycle unless the result side stalls; the rate is set by the pipelined
// divider, which resolves one quotient bit per stage over FRAC_BITS + 1 stages.
// Reset (synchronous, active high) empties every stage; there is no kept state.
// Depends on mwm_pkg, mwm_mix, mwm_div and mwm_out.
module mecanum_wheel_mixer_top #(
   parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mwm_pkg::cmd_type req_forward_cmd,
   input  mwm_pkg::cmd_type req_strafe_cmd,
   input  mwm_pkg::cmd_type req_rotate_cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mwm_pkg::cmd_type rsp_front_left,
   output mwm_pkg::cmd_type rsp_front_right,
   output mwm_pkg::cmd_type rsp_rear_left,
   output mwm_pkg::cmd_type rsp_rear_right,
   output logic             rsp_stop_all,
   output logic             rsp_was_scaled
);

   // The whole pipeline moves as one: it advances whenever the output
   // register is empty or its word is being taken. While the result side
   // stalls, a single skid word at the input still takes one command, and
   // req_stall is a plain register, so the two sides are parted.
   logic en;

   logic                      mix_valid;
   mwm_pkg::sign_vec_type     mix_sign;
   mwm_pkg::mag_vec_type      mix_mag;
   logic [mwm_pkg::MAG_W-1:0] mix_max;
   mwm_pkg::flags_type        mix_flags;

   logic                      div_valid;
   mwm_pkg::sign_vec_type     div_sign;
   mwm_pkg::mag_vec_type      div_mag;
   logic [mwm_pkg::NUM_WHEELS-1:0][FRAC_BITS:0] div_quo;
   mwm_pkg::flags_type        div_flags;

   assign en = !rsp_valid || !rsp_stall;

   // Front end: skid word, the four wheel sums (fl = f+s+r, fr = f-s-r,
   // rl = f-s+r, rr = f+s-r), their magnitudes, and the largest magnitude.
   // The hard-stop flag is raised here when all three requests are zero.
   mwm_mix u_mix (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_forward_cmd (req_forward_cmd),
      .req_strafe_cmd  (req_strafe_cmd),
      .req_rotate_cmd  (req_rotate_cmd),
      .out_valid       (mix_valid),
      .out_sign        (mix_sign),
      .out_mag         (mix_mag),
      .out_max         (mix_max),
      .out_flags       (mix_flags)
   );

   // Divider: every lane divides its magnitude times 1.0 by the largest
   // magnitude. Since no lane exceeds the largest, the quotient never
   // exceeds 1.0 and needs only FRAC_BITS + 1 bits. Dividing magnitudes
   // and applying the sign afterwards truncates toward zero.
   mwm_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mix_valid),
      .in_sign   (mix_sign),
      .in_mag    (mix_mag),
      .in_max    (mix_max),
      .in_flags  (mix_flags),
      .out_valid (div_valid),
      .out_sign  (div_sign),
      .out_mag   (div_mag),
      .out_quo   (div_quo),
      .out_flags (div_flags)
   );

   // Output register: the scaled quotient is used only when the largest
   // wheel exceeded 1.0; otherwise the plain sum passes, saturated to the
   // 16-bit word. A stop command yields zero sums and so zero wheels.
   mwm_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (div_valid),
      .in_sign         (div_sign),
      .in_mag          (div_mag),
      .in_quo          (div_quo),
      .in_flags        (div_flags),
      .rsp_valid       (rsp_valid),
      .rsp_front_left  (rsp_front_left),
      .rsp_front_right (rsp_front_right),
      .rsp_rear_left   (rsp_rear_left),
      .rsp_rear_right  (rsp_rear_right),
      .rsp_stop_all    (rsp_stop_all),
      .rsp_was_scaled  (rsp_was_scaled)
   );

endmodule

@@ bench/tb_mecanum_wheel_mixer_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the mecanum wheel mixer: directed command words, then random ones.
// Depends on mwm_pkg and mecanum_wheel_mixer_top from src.
module tb_mecanum_wheel_mixer_top;

   // The mixer runs at its default fraction width; the predictor follows it.
   localparam int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF;
   // Sizes the final wait for stray results after the last phase.
   localparam int LATENCY = FRAC_BITS + 4;
   // Cycles in a row with no word moving on either channel before the run is given up.
   // The slowest correct gap is the pipeline drain after a pause plus a long
   // stall streak.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES = 4;
   localparam int CMDS_PER_PHASE = 336;

   // One result word as the checker sees it, wheels in package lane order.
   typedef struct {
      mwm_pkg::cmd_type wheel [mwm_pkg::NUM_WHEELS];
      logic             stop_all;
      logic             was_scaled;
   } wheel_set_type;

   // Per command word: whether its result was typed into the table, and that result.
   typedef struct {
      bit            known;
      wheel_set_type wheels;
   } typed_answer_type;

   // A row of the directed table. Where known is clear, the wheel columns are unused
   // and the predictor supplies the expected result.
   typedef struct {
      int f, s, r;
      bit known;
      int fl, fr, rl, rr;
      bit stop, scaled;
   } cmd_row_type;

   localparam int NUM_ROWS = 24;

   cmd_row_type cmd_table [NUM_ROWS] = '{
      // Stop command straight after reset.
      '{0, 0, 0, 1, 0, 0, 0, 0, 1, 0},
      // Each request alone at full scale, both signs: exactly 1.0, so no scaling.
      '{16384, 0, 0, 1, 16384, 16384, 16384, 16384, 0, 0},
      '{-16384, 0, 0, 1, -16384, -16384, -16384, -16384, 0, 0},
      '{0, 16384, 0, 1, 16384, -16384, -16384, 16384, 0, 0},
      '{0, -16384, 0, 1, -16384, 16384, 16384, -16384, 0, 0},
      '{0, 0, 16384, 1, 16384, -16384, 16384, -16384, 0, 0},
      '{0, 0, -16384, 1, -16384, 16384, -16384, 16384, 0, 0},
      // Smallest nonzero requests.
      '{1, 0, 0, 1, 1, 1, 1, 1, 0, 0},
      '{0, 1, 0, 1, 1, -1, -1, 1, 0, 0},
      '{0, 0, -1, 1, -1, 1, -1, 1, 0, 0},
      // A wheel sum landing exactly on 1.0, then one step past it.
      '{8192, 8192, 0, 1, 16384, 0, 0, 16384, 0, 0},
      '{8192, 8192, 1, 0, 0, 0, 0, 0, 0, 0},
      '{16385, 0, 0, 1, 16384, 16384, 16384, 16384, 0, 1},
      // All three at full scale: the largest wheel is 3.0 and the rest truncate.
      '{16384, 16384, 16384, 1, 16384, -5461, 5461, 5461, 0, 1},
      '{-16384, -16384, -16384, 1, -16384, 5461, -5461, -5461, 0, 1},
      '{16384, -16384, 16384, 0, 0, 0, 0, 0, 0, 0},
      // Requests beyond the stated range use every bit pattern's signed value.
      '{-32768, 0, 0, 1, -16384, -16384, -16384, -16384, 0, 1},
      '{32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, 32767, -32768, 0, 0, 0, 0, 0, 0, 0},
      '{32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
      // Stop again after moving, then a few ordinary commands.
      '{0, 0, 0, 1, 0, 0, 0, 0, 1, 0},
      '{-1, -1, -1, 0, 0, 0, 0, 0, 0, 0},
      '{12345, -4321, 2000, 0, 0, 0, 0, 0, 0, 0}
   };

   string WHEEL_LABEL [mwm_pkg::NUM_WHEELS] =
      '{"front_left", "front_right", "rear_left", "rear_right"};

   // Sender idle and receiver stall odds, in percent, for each random phase.
   int GAP_PCT   [NUM_PHASES] = '{0, 57, 0, 19};
   int STALL_PCT [NUM_PHASES] = '{0, 0, 57, 19};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mwm_pkg::cmd_type req_forward_cmd = '0;
   mwm_pkg::cmd_type req_strafe_cmd = '0;
   mwm_pkg::cmd_type req_rotate_cmd = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mwm_pkg::cmd_type rsp_front_left;
   mwm_pkg::cmd_type rsp_front_right;
   mwm_pkg::cmd_type rsp_rear_left;
   mwm_pkg::cmd_type rsp_rear_right;
   logic             rsp_stop_all;
   logic             rsp_was_scaled;

   typed_answer_type typed_answer_q [$];
   wheel_set_type    pending_wheels_q [$];
   int               cmds_in_flight = 0;
   int               error_count = 0;
   int               idle_cycles = 0;
   int               gap_pct = 0;
   int               stall_pct = 0;
   int               cmds_sent = 0;
   int               results_seen = 0;
   int               stops_seen = 0;
   int               scaled_seen = 0;

   mecanum_wheel_mixer_top #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_forward_cmd(req_forward_cmd),
      .req_strafe_cmd(req_strafe_cmd),
      .req_rotate_cmd(req_rotate_cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_front_left(rsp_front_left),
      .rsp_front_right(rsp_front_right),
      .rsp_rear_left(rsp_rear_left),
      .rsp_rear_right(rsp_rear_right),
      .rsp_stop_all(rsp_stop_all),
      .rsp_was_scaled(rsp_was_scaled)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mixes one command into four wheel commands. The sums are formed at full
   // width so nothing overflows; if the largest magnitude is above 1.0, every
   // wheel is rescaled by 1.0 over that magnitude with truncation toward zero,
   // which is what integer division does here. The final clamp only matters
   // for fraction widths above 14, where an unscaled wheel can outgrow 16 bits.
   function automatic wheel_set_type mix_wheels(mwm_pkg::cmd_type f, mwm_pkg::cmd_type s,
                                                mwm_pkg::cmd_type r);
      longint        one;
      longint        peak;
      longint        sum [mwm_pkg::NUM_WHEELS];
      wheel_set_type result;
      one = longint'(1) << FRAC_BITS;
      result.stop_all = 1'b0;
      result.was_scaled = 1'b0;
      foreach (result.wheel[i]) result.wheel[i] = '0;
      if (f == 0 && s == 0 && r == 0) begin
         result.stop_all = 1'b1;
         return result;
      end
      sum[mwm_pkg::WHL_FL] = longint'(f) + longint'(s) + longint'(r);
      sum[mwm_pkg::WHL_FR] = longint'(f) - longint'(s) - longint'(r);
      sum[mwm_pkg::WHL_RL] = longint'(f) - longint'(s) + longint'(r);
      sum[mwm_pkg::WHL_RR] = longint'(f) + longint'(s) - longint'(r);
      peak = 0;
      foreach (sum[i]) begin
         if (sum[i] > peak) peak = sum[i];
         if (-sum[i] > peak) peak = -sum[i];
      end
      if (peak > one) begin
         result.was_scaled = 1'b1;
         foreach (sum[i]) sum[i] = (sum[i] * one) / peak;
      end
      foreach (sum[i]) begin
         if (sum[i] > 32767) sum[i] = 32767;
         if (sum[i] < -32768) sum[i] = -32768;
         result.wheel[i] = mwm_pkg::cmd_type'(sum[i]);
      end
      return result;
   endfunction

   // Random request field. Most values sit in the stated range; some are zero,
   // tiny, exactly full scale, or any 16-bit pattern so every bit toggles.
   function automatic mwm_pkg::cmd_type random_request();
      case ($urandom_range(9))
         0: return '0;
         1: return mwm_pkg::cmd_type'($urandom);
         2: return mwm_pkg::cmd_type'($urandom_range(16) - 8);
         3: return $urandom_range(1) ? mwm_pkg::cmd_type'(16384) : mwm_pkg::cmd_type'(-16384);
         default: return mwm_pkg::cmd_type'($urandom_range(32768) - 16384);
      endcase
   endfunction

   // Offers one command word. The answer note is queued before valid rises, so
   // the checker can pair it with the word at its handshake. Valid is lowered
   // only for a sender gap and is otherwise left high from the previous word.
   task automatic send_command(input mwm_pkg::cmd_type f, input mwm_pkg::cmd_type s,
                               input mwm_pkg::cmd_type r, input bit known,
                               input wheel_set_type wheels);
      typed_answer_q.push_back('{known, wheels});
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_forward_cmd <= f;
      req_strafe_cmd <= s;
      req_rotate_cmd <= r;
      do @(posedge clock); while (req_stall);
      cmds_sent++;
   endtask

   // Holds the sender off until every command in flight has produced its result.
   // The extra edge first lets the checker count the last accepted word.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (cmds_in_flight == 0);
      @(posedge clock);
   endtask

   // The receiver stalls at the odds of the current phase.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Checker and watchdog. Ports are sampled at the edge, before any driver
   // update of that edge lands, so the handshakes seen are the ones the mixer sees.
   always @(posedge clock) begin : result_check
      typed_answer_type note;
      wheel_set_type    want;
      wheel_set_type    got;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            note = typed_answer_q.pop_front();
            if (note.known) want = note.wheels;
            else want = mix_wheels(req_forward_cmd, req_strafe_cmd, req_rotate_cmd);
            pending_wheels_q.push_back(want);
            cmds_in_flight++;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_seen++;
            if (rsp_stop_all) stops_seen++;
            if (rsp_was_scaled) scaled_seen++;
            if (pending_wheels_q.size() == 0) begin
               $error("result word with no command waiting for it");
               error_count++;
            end else begin
               want = pending_wheels_q.pop_front();
               cmds_in_flight--;
               got.wheel[mwm_pkg::WHL_FL] = rsp_front_left;
               got.wheel[mwm_pkg::WHL_FR] = rsp_front_right;
               got.wheel[mwm_pkg::WHL_RL] = rsp_rear_left;
               got.wheel[mwm_pkg::WHL_RR] = rsp_rear_right;
               got.stop_all = rsp_stop_all;
               got.was_scaled = rsp_was_scaled;
               for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
                  if (got.wheel[i] !== want.wheel[i]) begin
                     $error("%s: expected %0d, got %0d", WHEEL_LABEL[i],
                            want.wheel[i], got.wheel[i]);
                     error_count++;
                  end
               end
               if (got.stop_all !== want.stop_all) begin
                  $error("stop_all: expected %0b, got %0b", want.stop_all, got.stop_all);
                  error_count++;
               end
               if (got.was_scaled !== want.was_scaled) begin
                  $error("was_scaled: expected %0b, got %0b", want.was_scaled,
                         got.was_scaled);
                  error_count++;
               end
            end
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      cmd_row_type      row;
      wheel_set_type    wheels;
      mwm_pkg::cmd_type f, s, r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table with no idling on either side.
      for (int n = 0; n < NUM_ROWS; n++) begin
         row = cmd_table[n];
         wheels.wheel[mwm_pkg::WHL_FL] = mwm_pkg::cmd_type'(row.fl);
         wheels.wheel[mwm_pkg::WHL_FR] = mwm_pkg::cmd_type'(row.fr);
         wheels.wheel[mwm_pkg::WHL_RL] = mwm_pkg::cmd_type'(row.rl);
         wheels.wheel[mwm_pkg::WHL_RR] = mwm_pkg::cmd_type'(row.rr);
         wheels.stop_all = row.stop;
         wheels.was_scaled = row.scaled;
         send_command(mwm_pkg::cmd_type'(row.f), mwm_pkg::cmd_type'(row.s),
                      mwm_pkg::cmd_type'(row.r), row.known, wheels);
      end
      drain_pipeline();

      // Random commands. The idle odds only change with the pipeline empty, and
      // each phase ends by waiting for every outstanding result.
      for (int p = 0; p < NUM_PHASES; p++) begin
         gap_pct = GAP_PCT[p];
         stall_pct = STALL_PCT[p];
         repeat (CMDS_PER_PHASE) begin
            if ($urandom_range(39) == 0) begin
               f = '0;
               s = '0;
               r = '0;
            end else begin
               f = random_request();
               s = random_request();
               r = random_request();
            end
            send_command(f, s, r, 1'b0, wheels);
         end
         drain_pipeline();
      end

      stall_pct = 0;
      repeat (LATENCY + 4) @(posedge clock);
      if (pending_wheels_q.size() != 0) begin
         $error("%0d command words never produced a result", pending_wheels_q.size());
         error_count++;
      end
      $display("Mixed %0d command words into %0d result words (%0d stops, %0d normalized),",
               cmds_sent, results_seen, stops_seen, scaled_seen);
      $display("over four idle and stall patterns; %0d errors found.", error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/mwm_pkg.sv
src/mwm_mix.sv
src/mwm_div.sv
src/mwm_out.sv
src/mecanum_wheel_mixer_top.sv
bench/tb_mecanum_wheel_mixer_top.sv
